@@ src/lrs_pkg.sv @@
// lrs_pkg: shared types and constants of the link roaming supervisor
// depends on nothing; used by every module in src

package lrs_pkg;

  localparam int unsigned SlotCount = 4;

  typedef enum logic [1:0] {
    ModeRecord  = 2'd0,
    ModeOutcome = 2'd1,
    ModeTick    = 2'd2,
    ModeLoss    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PhScan = 2'd0,
    PhConn = 2'd1,
    PhUp   = 2'd2,
    PhDeg  = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    ActNone       = 4'd0,
    ActWaitRescan = 4'd1,
    ActConnect    = 4'd2,
    ActRetry      = 4'd3,
    ActGiveUp     = 4'd4,
    ActUp         = 4'd5,
    ActRoamScan   = 4'd6,
    ActStay       = 4'd7,
    ActSwitch     = 4'd8,
    ActLost       = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    CfgWarnLevel     = 2'd0,
    CfgCriticalLevel = 2'd1,
    CfgWeakConfirm   = 2'd2,
    CfgRetries       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] warn_level;
    logic signed [7:0] critical_level;
    logic [7:0]        weak_confirm_count;
    logic [3:0]        retries_per_slot;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              match_valid;
    logic [1:0]        slot_index;
    logic signed [7:0] signal_dbm;
    logic              last_record;
    logic              got_address;
    logic              sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  link_state;
    logic [3:0]  action;
    logic [1:0]  target_slot;
    logic        weak_flag;
    logic [3:0]  attempt_number;
    logic [31:0] switch_count;
    logic [31:0] reconnect_count;
  } out_item_t;

endpackage

@@ src/link_roaming_supervisor_unit.sv @@
// link_roaming_supervisor_unit: top level, input register, result register
// depends on lrs_pkg, lrs_cfg_regs, lrs_core
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i (lrs_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (lrs_pkg::out_item_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle sustained while out_ready_i holds; from input acceptance to result valid
// the item passes the input register, then the state update into the result register
// reset clears the valid flags and the core state, config registers take their default values
// a stalled result holds the input register; in_ready_o stays high while the input
// register is empty or moves on

module link_roaming_supervisor_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lrs_pkg::in_item_t     in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lrs_pkg::out_item_t    out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i
);

  logic               in_valid_q;
  lrs_pkg::in_item_t  in_data_q;
  logic               out_valid_q;
  lrs_pkg::out_item_t out_data_q;
  logic               advance;
  logic               step;
  lrs_pkg::cfg_t      cfg;
  lrs_pkg::out_item_t result;

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  lrs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg),
    .item_i   (in_data_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ src/lrs_cfg_regs.sv @@
// lrs_cfg_regs: configuration register bank of the link roaming supervisor
// depends on lrs_pkg

module lrs_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  output lrs_pkg::cfg_t       cfg_o
);

  lrs_pkg::cfg_t cfg_q;
  lrs_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (lrs_pkg::cfg_idx_e'(cfg_idx_i))
        lrs_pkg::CfgWarnLevel:     cfg_d.warn_level         = cfg_wdata_i;
        lrs_pkg::CfgCriticalLevel: cfg_d.critical_level     = cfg_wdata_i;
        lrs_pkg::CfgWeakConfirm:   cfg_d.weak_confirm_count = cfg_wdata_i;
        lrs_pkg::CfgRetries:       cfg_d.retries_per_slot   = cfg_wdata_i[3:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_level         <= -8'sd70;
      cfg_q.critical_level     <= -8'sd80;
      cfg_q.weak_confirm_count <= 8'd3;
      cfg_q.retries_per_slot   <= 4'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/lrs_core.sv @@
// lrs_core: supervisor state and the per-event update logic
// depends on lrs_pkg

module lrs_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  lrs_pkg::cfg_t         cfg_i,
  input  lrs_pkg::in_item_t     item_i,
  output lrs_pkg::out_item_t    result_o
);

  lrs_pkg::phase_e   phase_q, phase_d;
  logic              roam_q, roam_d;
  logic              loss_q, loss_d;
  logic [1:0]        cur_slot_q, cur_slot_d;
  logic              best_found_q, best_found_d;
  logic signed [7:0] best_sig_q, best_sig_d;
  logic [1:0]        best_slot_q, best_slot_d;
  logic [3:0]        attempt_q, attempt_d;
  logic [7:0]        streak_q, streak_d;
  logic              weak_q, weak_d;
  logic [31:0]       switches_q, switches_d;
  logic [31:0]       reconnects_q, reconnects_d;
  lrs_pkg::action_e  action;

  logic              slot_ok;
  logic              hit;
  logic              better;
  logic [3:0]        limit;
  logic signed [7:0] sig;

  always_comb begin
    sig     = $signed(item_i.signal_dbm);
    slot_ok = {3'b000, item_i.slot_index} < 5'(lrs_pkg::SlotCount);
    hit     = item_i.match_valid && slot_ok;
    better  = !best_found_q || (sig > best_sig_q) ||
              ((sig == best_sig_q) && (item_i.slot_index < best_slot_q));
    limit   = (cfg_i.retries_per_slot == 4'd0) ? 4'd1 : cfg_i.retries_per_slot;

    phase_d      = phase_q;
    roam_d       = roam_q;
    loss_d       = loss_q;
    cur_slot_d   = cur_slot_q;
    best_found_d = best_found_q;
    best_sig_d   = best_sig_q;
    best_slot_d  = best_slot_q;
    attempt_d    = attempt_q;
    streak_d     = streak_q;
    weak_d       = weak_q;
    switches_d   = switches_q;
    reconnects_d = reconnects_q;
    action       = lrs_pkg::ActNone;

    case (lrs_pkg::mode_e'(item_i.mode))
      lrs_pkg::ModeRecord: begin
        if (phase_q == lrs_pkg::PhScan) begin
          if (hit && better) begin
            best_found_d = 1'b1;
            best_sig_d   = sig;
            best_slot_d  = item_i.slot_index;
          end
          if (item_i.last_record) begin
            if (roam_q) begin
              if (best_found_d && (best_slot_d != cur_slot_q)) begin
                switches_d = switches_q + 32'd1;
                cur_slot_d = best_slot_d;
                phase_d    = lrs_pkg::PhScan;
                roam_d     = 1'b0;
                loss_d     = 1'b0;
                weak_d     = 1'b0;
                action     = lrs_pkg::ActSwitch;
              end else if (loss_q) begin
                phase_d = lrs_pkg::PhScan;
                roam_d  = 1'b0;
                loss_d  = 1'b0;
                weak_d  = 1'b0;
                action  = lrs_pkg::ActLost;
              end else begin
                roam_d  = 1'b0;
                phase_d = lrs_pkg::PhDeg;
                action  = lrs_pkg::ActStay;
              end
            end else if (!best_found_d) begin
              action = lrs_pkg::ActWaitRescan;
            end else begin
              cur_slot_d   = best_slot_d;
              phase_d      = lrs_pkg::PhConn;
              attempt_d    = 4'd1;
              reconnects_d = reconnects_q + 32'd1;
              weak_d       = 1'b0;
              action       = lrs_pkg::ActConnect;
            end
            best_found_d = 1'b0;
            best_sig_d   = -8'sd128;
            best_slot_d  = 2'd0;
          end
        end
      end
      lrs_pkg::ModeOutcome: begin
        if (phase_q == lrs_pkg::PhConn) begin
          if (item_i.got_address) begin
            phase_d  = lrs_pkg::PhUp;
            streak_d = 8'd0;
            weak_d   = 1'b0;
            action   = lrs_pkg::ActUp;
          end else if (attempt_q < limit) begin
            attempt_d = attempt_q + 4'd1;
            action    = lrs_pkg::ActRetry;
          end else begin
            phase_d      = lrs_pkg::PhScan;
            roam_d       = 1'b0;
            loss_d       = 1'b0;
            weak_d       = 1'b0;
            best_found_d = 1'b0;
            best_sig_d   = -8'sd128;
            best_slot_d  = 2'd0;
            action       = lrs_pkg::ActGiveUp;
          end
        end
      end
      lrs_pkg::ModeTick: begin
        if (((phase_q == lrs_pkg::PhUp) || (phase_q == lrs_pkg::PhDeg)) && !roam_q &&
            item_i.sample_valid) begin
          if (!(sig < cfg_i.warn_level)) begin
            weak_d   = 1'b0;
            streak_d = 8'd0;
            phase_d  = lrs_pkg::PhUp;
          end else begin
            weak_d   = 1'b1;
            streak_d = (streak_q == 8'hff) ? streak_q : streak_q + 8'd1;
            phase_d  = lrs_pkg::PhDeg;
            if ((sig < cfg_i.critical_level) || (streak_d >= cfg_i.weak_confirm_count)) begin
              streak_d     = 8'd0;
              roam_d       = 1'b1;
              loss_d       = 1'b0;
              phase_d      = lrs_pkg::PhScan;
              best_found_d = 1'b0;
              best_sig_d   = -8'sd128;
              best_slot_d  = 2'd0;
              action       = lrs_pkg::ActRoamScan;
            end
          end
        end
      end
      lrs_pkg::ModeLoss: begin
        if (roam_q) begin
          loss_d = 1'b1;
        end else if ((phase_q == lrs_pkg::PhUp) || (phase_q == lrs_pkg::PhDeg)) begin
          phase_d      = lrs_pkg::PhScan;
          roam_d       = 1'b0;
          loss_d       = 1'b0;
          weak_d       = 1'b0;
          best_found_d = 1'b0;
          best_sig_d   = -8'sd128;
          best_slot_d  = 2'd0;
          action       = lrs_pkg::ActLost;
        end
      end
      default: action = lrs_pkg::ActNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= lrs_pkg::PhScan;
      roam_q       <= 1'b0;
      loss_q       <= 1'b0;
      cur_slot_q   <= 2'd0;
      best_found_q <= 1'b0;
      best_sig_q   <= -8'sd128;
      best_slot_q  <= 2'd0;
      attempt_q    <= 4'd0;
      streak_q     <= 8'd0;
      weak_q       <= 1'b0;
      switches_q   <= 32'd0;
      reconnects_q <= 32'd0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      roam_q       <= roam_d;
      loss_q       <= loss_d;
      cur_slot_q   <= cur_slot_d;
      best_found_q <= best_found_d;
      best_sig_q   <= best_sig_d;
      best_slot_q  <= best_slot_d;
      attempt_q    <= attempt_d;
      streak_q     <= streak_d;
      weak_q       <= weak_d;
      switches_q   <= switches_d;
      reconnects_q <= reconnects_d;
    end
  end

  assign result_o.link_state      = phase_d;
  assign result_o.action          = action;
  assign result_o.target_slot     = cur_slot_d;
  assign result_o.weak_flag       = weak_d;
  assign result_o.attempt_number  = attempt_d;
  assign result_o.switch_count    = switches_d;
  assign result_o.reconnect_count = reconnects_d;

endmodule
